FILE: rtl/mheap_pkg.sv
// Shared types, codes and constants for the binary max-heap block.
// No dependencies; compiled first.

package mheap_pkg;

  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned ECNT_W       = 8;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_SCAN,
    S_LAST,
    S_PAR_CMP,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_LONE,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic a_gt_b;
    logic a_eq_b;
  } cmp_res_t;

  typedef struct packed {
    status_t                    status;
    logic [ECNT_W-1:0]          entry_count;
    logic signed [KEY_W-1:0]    top_value;
  } res_t;

endpackage

FILE: rtl/mheap_if.sv
// Valid/ready channel interfaces for the heap block: request and result.
// Depends on mheap_pkg.

interface mheap_in_if import mheap_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic signed [KEY_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mheap_out_if import mheap_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [ECNT_W-1:0]       entry_count;
  logic signed [KEY_W-1:0] top_value;

  modport source (output valid, output status, output entry_count, output top_value,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input top_value,
                  output ready);
endinterface

FILE: rtl/max_heap_insert_delete_top.sv
// Top level of the binary max-heap: request channel, sequencer, result register.
// Depends on mheap_pkg, mheap_if and mheap_seq.
//
//   channel   dir   payload                              transfer when
//   in_chan   in    mode, value                          valid && ready
//   out_chan  out   status, entry_count, top_value       valid && ready
//
// Insert: climbs one level per parent compare; a full heap goes straight to the result.
// Delete: scans from slot 0, one store read a cycle, to a hit or a miss (empty heap: no scan);
// a hit off the last slot moves the last entry there and sifts it up or down.
// Reset clears the count and control only; no clearing pass over the store.
// in_chan.ready is high only while the sequencer is idle; a finished
// result waits in the sequencer until the output register is free.

module max_heap_insert_delete_top import mheap_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mheap_in_if.sink    in_chan,
  mheap_out_if.source out_chan
);

  logic idle;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_vld_r, out_vld_nxt;
  res_t out_res_r;

  mheap_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_chan.valid && in_chan.ready),
    .start_mode  (in_chan.mode),
    .start_value (in_chan.value),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign in_chan.ready = idle;
  assign res_ready     = !out_vld_r || out_chan.ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (res_ready) begin
      out_vld_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.status      = out_res_r.status;
  assign out_chan.entry_count = out_res_r.entry_count;
  assign out_chan.top_value   = out_res_r.top_value;

endmodule

FILE: rtl/mheap_cmp.sv
// Shared signed key comparator used by the compare steps of the heap sequencer.
// Depends on mheap_pkg.

module mheap_cmp import mheap_pkg::*; (
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output cmp_res_t                res
);

  assign res.a_gt_b = (a > b);
  assign res.a_eq_b = (a == b);

endmodule

FILE: rtl/mheap_seq.sv
// Heap sequencer: entry store, count, scan and sift control over one comparator.
// Depends on mheap_pkg and mheap_cmp.

module mheap_seq import mheap_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    start_mode,
  input  logic signed [KEY_W-1:0] start_value,
  output logic                    idle,
  output logic                    res_valid,
  input  logic                    res_ready,
  output res_t                    res
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CW1   = CNT_W + 1;

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rdata_r;
  logic [IDX_W-1:0]        raddr;
  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic signed [KEY_W-1:0] wdata;

  seq_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic signed [KEY_W-1:0] lval_r, lval_nxt;
  logic [IDX_W-1:0]        child_r, child_nxt;
  logic signed [KEY_W-1:0] cval_r, cval_nxt;
  status_t                 status_r, status_nxt;
  logic signed [KEY_W-1:0] top_r;

  logic signed [KEY_W-1:0] op_a, op_b;
  cmp_res_t                cmp;
  logic [IDX_W-1:0]        parent;
  logic [CW1-1:0]          lc, rc;
  logic [CNT_W-1:0]        last;
  logic                    issue;

  mheap_cmp u_cmp (
    .a   (op_a),
    .b   (op_b),
    .res (cmp)
  );

  assign parent = (pos_r - IDX_W'(1)) >> 1;
  assign lc     = CW1'({pos_r, 1'b1});
  assign rc     = lc + CW1'(1);
  assign last   = count_r - CNT_W'(1);
  assign issue  = (rd_idx_r < count_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    pos_r    <= pos_nxt;
    rd_idx_r <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    lval_r   <= lval_nxt;
    child_r  <= child_nxt;
    cval_r   <= cval_nxt;
    status_r <= status_nxt;
    if (we && waddr == '0) begin
      top_r <= wdata;
    end
  end

  always_comb begin
    op_a = key_r;
    op_b = rdata_r;
    case (state_r)
      S_DN_R:   begin op_a = rdata_r; op_b = lval_r; end
      S_DN_CMP: begin op_a = cval_r;  op_b = key_r;  end
      S_LONE:   begin op_a = rdata_r; op_b = key_r;  end
      default:  begin op_a = key_r;   op_b = rdata_r; end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    lval_nxt    = lval_r;
    child_nxt   = child_r;
    cval_nxt    = cval_r;
    status_nxt  = status_r;
    raddr       = '0;
    we          = 1'b0;
    waddr       = pos_r;
    wdata       = key_r;
    idle        = 1'b0;
    res_valid   = 1'b0;

    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          key_nxt    = start_value;
          status_nxt = ST_DONE;
          if (start_mode == MODE_INSERT) begin
            if (count_r >= CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_W'(1);
              state_nxt = S_UP_RD;
            end
          end else if (count_r == '0) begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            rd_idx_nxt = '0;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          raddr     = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (!cmp.a_gt_b) begin
          state_nxt = S_DONE;
        end else begin
          wdata     = rdata_r;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end
      end
      S_SCAN: begin
        raddr       = rd_idx_r[IDX_W-1:0];
        cmp_vld_nxt = issue;
        cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (cmp_vld_r && cmp.a_eq_b) begin
          cmp_vld_nxt = 1'b0;
          pos_nxt     = cmp_idx_r;
          count_nxt   = last;
          if (CNT_W'(cmp_idx_r) == last) begin
            state_nxt = S_DONE;
          end else begin
            raddr     = last[IDX_W-1:0];
            state_nxt = S_LAST;
          end
        end else if (cmp_vld_r && CNT_W'(cmp_idx_r) == last) begin
          cmp_vld_nxt = 1'b0;
          status_nxt  = ST_NOT_FOUND;
          state_nxt   = S_DONE;
        end
      end
      S_LAST: begin
        key_nxt = rdata_r;
        we      = 1'b1;
        wdata   = rdata_r;
        if (pos_r == '0) begin
          state_nxt = S_DN_CHK;
        end else begin
          raddr     = parent;
          state_nxt = S_PAR_CMP;
        end
      end
      S_PAR_CMP: begin
        if (cmp.a_gt_b) begin
          we        = 1'b1;
          wdata     = rdata_r;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        raddr = lc[IDX_W-1:0];
        if (rc < CW1'(count_r)) begin
          state_nxt = S_DN_L;
        end else if (lc < CW1'(count_r)) begin
          state_nxt = S_LONE;
        end else begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DN_L: begin
        lval_nxt  = rdata_r;
        raddr     = rc[IDX_W-1:0];
        state_nxt = S_DN_R;
      end
      S_DN_R: begin
        if (cmp.a_gt_b) begin
          child_nxt = rc[IDX_W-1:0];
          cval_nxt  = rdata_r;
        end else begin
          child_nxt = lc[IDX_W-1:0];
          cval_nxt  = lval_r;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (cmp.a_gt_b) begin
          wdata     = cval_r;
          pos_nxt   = child_r;
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LONE: begin
        we = 1'b1;
        if (cmp.a_gt_b) begin
          wdata     = rdata_r;
          pos_nxt   = lc[IDX_W-1:0];
          state_nxt = S_DN_CHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status      = status_r;
  assign res.entry_count = ECNT_W'(count_r);
  assign res.top_value   = (count_r != '0) ? top_r : '0;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_SCAN) |=> count_r == $past(count_r))
    else $error("entry count moved outside accept or scan");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == ST_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("full status with free slots");

  a_start_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> state_r != S_IDLE)
    else $error("accepted item not started");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> CNT_W'(waddr) < count_r)
    else $error("store written beyond live entries");

endmodule

FILE: verif/mheap_tracker.sv
// Transfer monitor and heap predictor for the max-heap block: keeps its own heap,
// queues the result due for each request and compares it with each result transfer.
// Depends on mheap_pkg and mheap_if.

module mheap_tracker import mheap_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  mheap_in_if   in_mon,
  mheap_out_if  out_mon,
  output int    mismatches,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int unsigned             live_count;
  res_t                    due_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
    live_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void lift_key(input logic signed [KEY_W-1:0] key, input int unsigned pos);
    int unsigned up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (key <= heap_keys[up]) break;
      heap_keys[pos] = heap_keys[up];
      pos = up;
    end
    heap_keys[pos] = key;
  endfunction

  function automatic void swap_keys(input int unsigned a, input int unsigned b);
    logic signed [KEY_W-1:0] t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void sink_key(input int unsigned pos);
    int unsigned lc;
    int unsigned rc;
    int unsigned pick;
    bit          settled;
    settled = 1'b0;
    lc = 2 * pos + 1;
    rc = 2 * pos + 2;
    while (!settled && rc < live_count) begin
      if (heap_keys[pos] >= heap_keys[lc] && heap_keys[pos] >= heap_keys[rc]) begin
        settled = 1'b1;
      end else begin
        pick = (heap_keys[rc] <= heap_keys[lc]) ? lc : rc;
        swap_keys(pos, pick);
        pos = pick;
        lc  = 2 * pos + 1;
        rc  = 2 * pos + 2;
      end
    end
    if (!settled && lc < live_count && heap_keys[lc] > heap_keys[pos]) begin
      swap_keys(pos, lc);
    end
  endfunction

  function automatic res_t apply_heap_op(input logic op, input logic signed [KEY_W-1:0] key);
    res_t        r;
    int unsigned i;
    bit          found;
    r.status = ST_DONE;
    if (op == MODE_INSERT) begin
      if (live_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        lift_key(key, live_count);
        live_count++;
      end
    end else begin
      found = 1'b0;
      i     = 0;
      while (!found && i < live_count) begin
        if (heap_keys[i] == key) found = 1'b1;
        else i++;
      end
      if (!found) begin
        r.status = ST_NOT_FOUND;
      end else begin
        live_count--;
        if (i < live_count) begin
          heap_keys[i] = heap_keys[live_count];
          if (i > 0 && heap_keys[i] > heap_keys[(i - 1) / 2]) lift_key(heap_keys[i], i);
          else sink_key(i);
        end
      end
    end
    r.entry_count = ECNT_W'(live_count);
    r.top_value   = (live_count > 0) ? heap_keys[0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        due_results.push_back(apply_heap_op(in_mon.mode, in_mon.value));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with no result due");
        end else begin
          want = due_results.pop_front();
          if (out_mon.status !== want.status) begin
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, out_mon.status));
          end
          if (out_mon.entry_count !== want.entry_count) begin
            report_mismatch($sformatf("entry_count expected %0d got %0d",
                                      want.entry_count, out_mon.entry_count));
          end
          if (out_mon.top_value !== want.top_value) begin
            report_mismatch($sformatf("top_value expected %0d got %0d",
                                      want.top_value, out_mon.top_value));
          end
        end
      end
    end
    outstanding <= due_results.size();
  end

endmodule

FILE: verif/tb_max_heap_insert_delete_top.sv
// Testbench top for the max-heap block: clock, reset, request and result-ready stimulus
// and verdict. Depends on mheap_pkg, mheap_if, the block's RTL and mheap_tracker.

module tb_max_heap_insert_delete_top import mheap_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_CAP       = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned ITEMS_PER_PASS = 250;
  localparam int unsigned TAIL_CYCLES    = 300;

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   failures;
  int   waiting;
  int   cycle_count;
  bit   filling;

  logic signed [KEY_W-1:0] held_keys [$];

  mheap_in_if  in_chan ();
  mheap_out_if out_chan ();

  max_heap_insert_delete_top #(.CAPACITY(HEAP_CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mheap_tracker #(.CAPACITY(HEAP_CAP)) tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .mismatches  (failures),
    .outstanding (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.mode   = MODE_INSERT;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    int unsigned             sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      k = $urandom_range(0, 31);
      k = k - 32'sd16;
    end else if (sel < 8) begin
      k = $urandom;
    end else if (sel == 8) begin
      case ($urandom_range(0, 3))
        0:       k = 32'sh7FFFFFFF;
        1:       k = 32'sh80000000;
        2:       k = '0;
        default: k = '1;
      endcase
    end else begin
      k = $urandom_range(0, 7);
      k = $urandom_range(0, 1) ? 32'sh7FFFFFFF - k : 32'sh80000000 + k;
    end
    return k;
  endfunction

  task automatic send_item(input logic op, input logic signed [KEY_W-1:0] key);
    int idx;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.mode  <= op;
    in_chan.value <= key;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    // track the live keys so that deletes can target them
    if (op == MODE_INSERT) begin
      if (held_keys.size() < HEAP_CAP) held_keys.push_back(key);
    end else begin
      idx = -1;
      foreach (held_keys[k]) begin
        if (held_keys[k] == key) begin
          idx = k;
          break;
        end
      end
      if (idx >= 0) held_keys.delete(idx);
    end
  endtask

  initial begin : stimulus
    int                      src_pcts  [4];
    int                      sink_pcts [4];
    logic                    op;
    logic signed [KEY_W-1:0] key;
    src_pcts  = '{0, 48, 0, 15};
    sink_pcts = '{0, 0, 48, 15};
    filling   = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_item(MODE_DELETE, 32'sd0);
    send_item(MODE_INSERT, 32'sh7FFFFFFF);
    send_item(MODE_INSERT, 32'sh80000000);
    send_item(MODE_INSERT, 32'sd0);
    send_item(MODE_INSERT, -32'sd1);
    send_item(MODE_DELETE, 32'sd123);
    send_item(MODE_DELETE, 32'sh80000000);
    send_item(MODE_DELETE, 32'sh7FFFFFFF);
    send_item(MODE_DELETE, -32'sd1);
    send_item(MODE_DELETE, 32'sd0);
    send_item(MODE_INSERT, 32'sd5);
    send_item(MODE_DELETE, 32'sd5);
    send_item(MODE_INSERT, 32'sd10);
    send_item(MODE_INSERT, 32'sd9);
    send_item(MODE_INSERT, 32'sd8);
    send_item(MODE_INSERT, 32'sd7);
    send_item(MODE_INSERT, 32'sd1);
    send_item(MODE_DELETE, 32'sd10);
    send_item(MODE_INSERT, 32'sd9);
    send_item(MODE_DELETE, 32'sd9);
    send_item(MODE_DELETE, 32'sd8);
    send_item(MODE_DELETE, 32'sd1);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = src_pcts[p];
      sink_stall_pct = sink_pcts[p];
      repeat (ITEMS_PER_PASS) begin
        // fill to capacity and beyond, then drain toward empty
        if (filling) begin
          if (held_keys.size() == HEAP_CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
        end else if (held_keys.size() == 0 || $urandom_range(0, 63) == 0) begin
          filling = 1'b1;
        end
        op = ($urandom_range(0, 99) < (filling ? 85 : 15)) ? MODE_INSERT : MODE_DELETE;
        if (op == MODE_DELETE && held_keys.size() > 0 && $urandom_range(0, 9) != 0) begin
          key = held_keys[$urandom_range(0, held_keys.size() - 1)];
        end else begin
          key = pick_key();
        end
        send_item(op, key);
      end
    end
    in_chan.valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && waiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
